[sv/drtwp_pkg.sv]
// Shared types, constants and lookup functions for the depth ray to world point block.
package drtwp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_N     = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    localparam int STEP_W       = (CORDIC_N > 1) ? $clog2(CORDIC_N) : 1;

    localparam int ANG_W = 35;
    localparam int XY_W  = 34;
    localparam int WK_W  = 20;

    typedef logic signed [ANG_W-1:0] ang_t;
    typedef logic signed [XY_W-1:0]  cxy_t;
    typedef logic signed [WK_W-1:0]  wk_t;
    typedef logic signed [16:0]      term_t;
    typedef term_t [8:0]             term_mat_t;

    localparam ang_t ANG_HALF_PI  = 35'sd1686629713;
    localparam ang_t ANG_PI       = 35'sd3373259426;
    localparam cxy_t CORDIC_START = 34'sd652032874;

    localparam logic [2:0] REG_ROLL  = 3'd0;
    localparam logic [2:0] REG_PITCH = 3'd1;
    localparam logic [2:0] REG_YAW   = 3'd2;
    localparam logic [2:0] REG_SX    = 3'd3;
    localparam logic [2:0] REG_SY    = 3'd4;
    localparam logic [2:0] REG_SZ    = 3'd5;
    localparam logic [2:0] REG_FAR   = 3'd6;

    typedef enum logic [2:0] {
        RS_IDLE, RS_LOAD, RS_ITER, RS_ROUND, RS_MATRIX, RS_COMMIT
    } rot_state_t;

    typedef enum logic [3:0] {
        SRC_C1, SRC_S1, SRC_C2, SRC_S2, SRC_C3, SRC_S3, SRC_TA, SRC_TB, SRC_TC
    } op_src_t;

    typedef enum logic [1:0] {MOP_SET, MOP_ADD, MOP_SUB} mop_t;

    typedef struct packed {
        op_src_t    src_a;
        op_src_t    src_b;
        logic [3:0] dst;
        mop_t       op;
    } mstep_t;

    localparam int MSTEPS = 15;

    // destinations 0..8 are matrix entries, 9..11 partial products
    function automatic mstep_t mstep(input logic [3:0] k);
        mstep_t r;
        case (k)
            4'd0:  r = '{SRC_C1, SRC_S2, 4'd9,  MOP_SET};
            4'd1:  r = '{SRC_S1, SRC_S2, 4'd10, MOP_SET};
            4'd2:  r = '{SRC_C3, SRC_S1, 4'd11, MOP_SET};
            4'd3:  r = '{SRC_C1, SRC_C2, 4'd0,  MOP_SET};
            4'd4:  r = '{SRC_TA, SRC_S3, 4'd1,  MOP_SET};
            4'd5:  r = '{SRC_C3, SRC_S1, 4'd1,  MOP_SUB};
            4'd6:  r = '{SRC_S1, SRC_S3, 4'd2,  MOP_SET};
            4'd7:  r = '{SRC_TA, SRC_C3, 4'd2,  MOP_ADD};
            4'd8:  r = '{SRC_C2, SRC_S1, 4'd3,  MOP_SET};
            4'd9:  r = '{SRC_C1, SRC_C3, 4'd4,  MOP_SET};
            4'd10: r = '{SRC_TB, SRC_S3, 4'd4,  MOP_ADD};
            4'd11: r = '{SRC_TC, SRC_S2, 4'd5,  MOP_SET};
            4'd12: r = '{SRC_C1, SRC_S3, 4'd5,  MOP_SUB};
            4'd13: r = '{SRC_C2, SRC_S3, 4'd7,  MOP_SET};
            4'd14: r = '{SRC_C2, SRC_C3, 4'd8,  MOP_SET};
            default: r = '{SRC_C1, SRC_C1, 4'd0, MOP_ADD};
        endcase
        return r;
    endfunction

    function automatic ang_t atan_val(input logic [4:0] i);
        ang_t r;
        case (i)
            5'd0:  r = 35'sd843314856;
            5'd1:  r = 35'sd497837829;
            5'd2:  r = 35'sd263043836;
            5'd3:  r = 35'sd133525158;
            5'd4:  r = 35'sd67021686;
            5'd5:  r = 35'sd33543515;
            5'd6:  r = 35'sd16775850;
            5'd7:  r = 35'sd8388437;
            5'd8:  r = 35'sd4194282;
            5'd9:  r = 35'sd2097149;
            5'd10: r = 35'sd1048575;
            5'd11: r = 35'sd524287;
            5'd12: r = 35'sd262143;
            5'd13: r = 35'sd131071;
            5'd14: r = 35'sd65535;
            5'd15: r = 35'sd32767;
            5'd16: r = 35'sd16383;
            5'd17: r = 35'sd8191;
            5'd18: r = 35'sd4095;
            5'd19: r = 35'sd2047;
            5'd20: r = 35'sd1023;
            5'd21: r = 35'sd511;
            5'd22: r = 35'sd255;
            5'd23: r = 35'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic term_t sat17(input logic signed [24:0] v);
        term_t r;
        if (v > 25'sd65535)
            r = 17'sd65535;
        else if (v < -25'sd65536)
            r = -17'sd65536;
        else
            r = v[16:0];
        return r;
    endfunction

endpackage

[sv/depth_ray_to_world_point.sv]
// An accepted request reaches m_tdata through the four pipeline stages.
// Throughput: one request per cycle; m_tready stalls the stages, but bubbles close up.
// Angle writes rebuild the rotation matrix on one shared CORDIC and one multiplier,
// with s_tready low meanwhile.
// Reset (aresetn low, synchronous) empties the pipeline, loads the register defaults
// and an exact identity rotation.
module depth_ray_to_world_point (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // dir_x, dir_y, dir_z, depth_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // point_x, point_y, point_z, range_mm, zero pad
    output logic [0:0]  m_tuser    // hit
);
    import drtwp_pkg::*;

    logic signed [15:0] roll_reg, pitch_reg, yaw_reg;
    logic signed [23:0] sx_reg, sy_reg, sz_reg;
    logic [15:0]        far_reg;
    logic               wr_en, ang_wr, busy;
    logic [2:0]         idx;
    term_mat_t          terms;
    logic signed [24:0] px, py, pz;
    logic [15:0]        rng;
    logic               hit, dp_ready;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign ang_wr = wr_en && (idx == REG_ROLL || idx == REG_PITCH || idx == REG_YAW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_reg  <= '0;
            pitch_reg <= '0;
            yaw_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= 24'sd2000;
            sz_reg    <= '0;
            far_reg   <= 16'd30000;
        end else if (wr_en) begin
            case (idx)
                REG_ROLL:  roll_reg  <= pwdata[15:0];
                REG_PITCH: pitch_reg <= pwdata[15:0];
                REG_YAW:   yaw_reg   <= pwdata[15:0];
                REG_SX:    sx_reg    <= pwdata[23:0];
                REG_SY:    sy_reg    <= pwdata[23:0];
                REG_SZ:    sz_reg    <= pwdata[23:0];
                REG_FAR:   far_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ROLL:  prdata = {16'b0, roll_reg};
            REG_PITCH: prdata = {16'b0, pitch_reg};
            REG_YAW:   prdata = {16'b0, yaw_reg};
            REG_SX:    prdata = {8'b0, sx_reg};
            REG_SY:    prdata = {8'b0, sy_reg};
            REG_SZ:    prdata = {8'b0, sz_reg};
            REG_FAR:   prdata = {16'b0, far_reg};
            default:   prdata = '0;
        endcase
    end

    drtwp_rot u_rot (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (ang_wr),
        .roll_angle  (roll_reg),
        .pitch_angle (pitch_reg),
        .yaw_angle   (yaw_reg),
        .terms       (terms),
        .busy        (busy)
    );

    assign s_tready = dp_ready && !busy;

    drtwp_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid && !busy),
        .in_ready     (dp_ready),
        .dir_x        (s_tdata[15:0]),
        .dir_y        (s_tdata[31:16]),
        .dir_z        (s_tdata[47:32]),
        .depth_code   (s_tdata[71:48]),
        .terms        (terms),
        .sensor_x_mm  (sx_reg),
        .sensor_y_mm  (sy_reg),
        .sensor_z_mm  (sz_reg),
        .far_plane_mm (far_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .point_x      (px),
        .point_y      (py),
        .point_z      (pz),
        .range_mm     (rng),
        .hit          (hit)
    );

    assign m_tdata = {5'b0, rng, pz, py, px};
    assign m_tuser = hit;

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready) else $error("request taken during matrix rebuild");

    a_ang_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        ang_wr |=> busy) else $error("angle write did not start a rebuild");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !hit) |-> (px == '0 && py == '0 && pz == '0 && rng == '0))
        else $error("invalid return with nonzero result");

endmodule

[sv/drtwp_rot.sv]
// Rotation matrix builder: shared CORDIC sine/cosine and one multiply per cycle.
module drtwp_rot (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [15:0]         roll_angle,
    input  logic signed [15:0]         pitch_angle,
    input  logic signed [15:0]         yaw_angle,
    output drtwp_pkg::term_mat_t       terms,
    output logic                       busy
);
    import drtwp_pkg::*;

    rot_state_t          state_reg, state_next;
    logic [1:0]          sel_reg, sel_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [3:0]          mstep_reg, mstep_next;
    cxy_t                x_reg, y_reg;
    ang_t                z_reg;
    logic                neg_reg;
    term_t               sn_reg [3];
    term_t               cs_reg [3];
    wk_t                 wk_reg [12];
    wk_t                 acc_reg;
    term_mat_t           terms_reg;

    logic signed [15:0]  ang_cur;
    ang_t                z0;
    cxy_t                xs, ys;
    logic [4:0]          at_idx;
    logic signed [XY_W-15:0] xr, yr;
    term_t               xq, yq;
    mstep_t              ms;
    wk_t                 opa, opb;
    logic signed [2*WK_W-1:0] prod;
    wk_t                 prod_q, acc_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RS_IDLE;
            sel_reg   <= '0;
            step_reg  <= '0;
            mstep_reg <= '0;
            for (int i = 0; i < 9; i++)
                terms_reg[i] <= (i % 4 == 0) ? 17'sd32768 : 17'sd0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
            mstep_reg <= mstep_next;
            if (state_reg == RS_COMMIT && !start) begin
                for (int i = 0; i < 9; i++)
                    terms_reg[i] <= (i == 6) ? -sn_reg[1] : sat17(25'(wk_reg[i]));
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        mstep_next = mstep_reg;
        case (state_reg)
            RS_IDLE: ;
            RS_LOAD: begin
                state_next = RS_ITER;
                step_next  = '0;
            end
            RS_ITER: begin
                if (step_reg == STEP_W'(CORDIC_N - 1))
                    state_next = RS_ROUND;
                else
                    step_next = step_reg + 1'b1;
            end
            RS_ROUND: begin
                if (sel_reg == 2'd2) begin
                    state_next = RS_MATRIX;
                    mstep_next = '0;
                end else begin
                    state_next = RS_LOAD;
                    sel_next   = sel_reg + 1'b1;
                end
            end
            RS_MATRIX: begin
                if (mstep_reg == 4'(MSTEPS - 1))
                    state_next = RS_COMMIT;
                else
                    mstep_next = mstep_reg + 1'b1;
            end
            RS_COMMIT: state_next = RS_IDLE;
            default:   state_next = RS_IDLE;
        endcase
        // a new angle write restarts the whole build
        if (start) begin
            state_next = RS_LOAD;
            sel_next   = 2'd0;
        end
    end

    // angle order: yaw, pitch, roll
    always_comb begin
        case (sel_reg)
            2'd0:    ang_cur = yaw_angle;
            2'd1:    ang_cur = pitch_angle;
            default: ang_cur = roll_angle;
        endcase
        z0 = {{(ANG_W-33){ang_cur[15]}}, ang_cur, 17'b0};
    end

    assign xs     = x_reg >>> step_reg;
    assign ys     = y_reg >>> step_reg;
    assign at_idx = 5'(step_reg);

    always_comb begin
        xr = (XY_W-14)'((x_reg + XY_W'(16384)) >>> 15);
        yr = (XY_W-14)'((y_reg + XY_W'(16384)) >>> 15);
        if (xr > 20'sd32768)       xq = 17'sd32768;
        else if (xr < -20'sd32768) xq = -17'sd32768;
        else                       xq = xr[16:0];
        if (yr > 20'sd32768)       yq = 17'sd32768;
        else if (yr < -20'sd32768) yq = -17'sd32768;
        else                       yq = yr[16:0];
        if (neg_reg) begin
            xq = -xq;
            yq = -yq;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            RS_LOAD: begin
                x_reg <= CORDIC_START;
                y_reg <= '0;
                if (z0 > ANG_HALF_PI) begin
                    z_reg   <= z0 - ANG_PI;
                    neg_reg <= 1'b1;
                end else if (z0 < -ANG_HALF_PI) begin
                    z_reg   <= z0 + ANG_PI;
                    neg_reg <= 1'b1;
                end else begin
                    z_reg   <= z0;
                    neg_reg <= 1'b0;
                end
            end
            RS_ITER: begin
                if (!z_reg[ANG_W-1]) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_val(at_idx);
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_val(at_idx);
                end
            end
            RS_ROUND: begin
                cs_reg[sel_reg] <= xq;
                sn_reg[sel_reg] <= yq;
            end
            RS_MATRIX: begin
                acc_reg            <= acc_new;
                wk_reg[ms.dst]     <= acc_new;
            end
            default: ;
        endcase
    end

    function automatic wk_t pick(input op_src_t s, input term_t c1, input term_t s1,
                                 input term_t c2, input term_t s2, input term_t c3,
                                 input term_t s3, input wk_t ta, input wk_t tb,
                                 input wk_t tc);
        wk_t r;
        case (s)
            SRC_C1:  r = WK_W'(c1);
            SRC_S1:  r = WK_W'(s1);
            SRC_C2:  r = WK_W'(c2);
            SRC_S2:  r = WK_W'(s2);
            SRC_C3:  r = WK_W'(c3);
            SRC_S3:  r = WK_W'(s3);
            SRC_TA:  r = ta;
            SRC_TB:  r = tb;
            SRC_TC:  r = tc;
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        ms  = mstep(mstep_reg);
        opa = pick(ms.src_a, cs_reg[0], sn_reg[0], cs_reg[1], sn_reg[1], cs_reg[2],
                   sn_reg[2], wk_reg[9], wk_reg[10], wk_reg[11]);
        opb = pick(ms.src_b, cs_reg[0], sn_reg[0], cs_reg[1], sn_reg[1], cs_reg[2],
                   sn_reg[2], wk_reg[9], wk_reg[10], wk_reg[11]);
        prod   = opa * opb;
        prod_q = WK_W'(prod >>> 15);
        case (ms.op)
            MOP_SET: acc_new = prod_q;
            MOP_ADD: acc_new = acc_reg + prod_q;
            MOP_SUB: acc_new = acc_reg - prod_q;
            default: acc_new = prod_q;
        endcase
    end

    assign terms = terms_reg;
    assign busy  = (state_reg != RS_IDLE);

endmodule

[sv/drtwp_dp.sv]
// Four-stage point pipeline: range, margin test, rotation and translation.
module drtwp_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [15:0]    dir_x,
    input  logic signed [15:0]    dir_y,
    input  logic signed [15:0]    dir_z,
    input  logic [23:0]           depth_code,
    input  drtwp_pkg::term_mat_t  terms,
    input  logic signed [23:0]    sensor_x_mm,
    input  logic signed [23:0]    sensor_y_mm,
    input  logic signed [23:0]    sensor_z_mm,
    input  logic [15:0]           far_plane_mm,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [24:0]    point_x,
    output logic signed [24:0]    point_y,
    output logic signed [24:0]    point_z,
    output logic [15:0]           range_mm,
    output logic                  hit
);
    import drtwp_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [39:0]               prod1_reg;
    logic signed [32:0]        mul1_reg [9];
    logic                      hit2_reg, hit3_reg;
    logic [15:0]               rng2_reg, rng3_reg;
    logic signed [34:0]        acc2_reg [3];
    logic [33:0]               pl3_reg [3];
    logic signed [33:0]        ph3_reg [3];
    logic signed [24:0]        pt4_reg [3];
    logic [15:0]               rng4_reg;
    logic                      hit4_reg;

    logic signed [15:0]        dir [3];
    logic signed [23:0]        pos [3];
    logic [43:0]               prod10, lim;
    logic [19:0]               far10;
    logic signed [25:0]        pnew [3];

    assign rdy4 = !v4_reg || out_ready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign dir[0] = dir_x;
    assign dir[1] = dir_y;
    assign dir[2] = dir_z;
    assign pos[0] = sensor_x_mm;
    assign pos[1] = sensor_y_mm;
    assign pos[2] = sensor_z_mm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // stage 1: range product and the nine rotation products
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            prod1_reg <= depth_code * far_plane_mm;
            for (int i = 0; i < 9; i++)
                mul1_reg[i] <= terms[i] * dir[i % 3];
        end
    end

    // stage 2: margin test and row sums
    assign far10  = {far_plane_mm, 3'b0} + {3'b0, far_plane_mm, 1'b0};
    assign lim    = {far10 - 20'd1, 24'b0};
    assign prod10 = {prod1_reg, 3'b0} + {3'b0, prod1_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            hit2_reg <= (far_plane_mm != '0) && (prod10 < lim);
            rng2_reg <= prod1_reg[39:24];
            for (int r = 0; r < 3; r++)
                acc2_reg[r] <= 35'(mul1_reg[3*r]) + 35'(mul1_reg[3*r+1])
                             + 35'(mul1_reg[3*r+2]);
        end
    end

    // stage 3: range times row sum, split into two partial products
    always_ff @(posedge aclk) begin
        if (rdy3) begin
            hit3_reg <= hit2_reg;
            rng3_reg <= rng2_reg;
            for (int r = 0; r < 3; r++) begin
                pl3_reg[r] <= rng2_reg * acc2_reg[r][17:0];
                ph3_reg[r] <= $signed({1'b0, rng2_reg}) * $signed(acc2_reg[r][34:18]);
            end
        end
    end

    // stage 4: recombine, floor shift, add position, clamp; a miss gives zero
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            logic signed [51:0] tot;
            tot = (52'(ph3_reg[r]) <<< 18) + $signed({18'b0, pl3_reg[r]});
            pnew[r] = 26'(pos[r]) + 26'(tot >>> 30);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            hit4_reg <= hit3_reg;
            rng4_reg <= hit3_reg ? rng3_reg : '0;
            for (int r = 0; r < 3; r++) begin
                if (!hit3_reg)
                    pt4_reg[r] <= '0;
                else if (pnew[r] > 26'sd8454142)
                    pt4_reg[r] <= 25'sd8454142;
                else if (pnew[r] < -26'sd8454143)
                    pt4_reg[r] <= -25'sd8454143;
                else
                    pt4_reg[r] <= pnew[r][24:0];
            end
        end
    end

    assign out_valid = v4_reg;
    assign point_x   = pt4_reg[0];
    assign point_y   = pt4_reg[1];
    assign point_z   = pt4_reg[2];
    assign range_mm  = rng4_reg;
    assign hit       = hit4_reg;

endmodule

[sim/depth_point_checker.sv]
// Stream monitor and result predictor for the depth ray to world point block.
module depth_point_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // dir_x, dir_y, dir_z, depth_code
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,   // point_x, point_y, point_z, range_mm, zero pad
    input  logic [0:0]  m_tuser,   // hit
    output int          errors,
    output int          pending
);
    import drtwp_pkg::*;

    localparam longint HALF_PI_Z  = 64'sd1686629713;
    localparam longint PI_Z       = 64'sd3373259426;
    localparam longint GAIN_START = 64'sd652032874;
    localparam longint PT_MAX     = 64'sd8454142;
    localparam longint PT_MIN     = -64'sd8454143;

    localparam longint ARCTAN [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149,
        1048575, 524287, 262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047, 1023, 511, 255, 127
    };

    typedef struct {
        logic signed [24:0] px;
        logic signed [24:0] py;
        logic signed [24:0] pz;
        logic [15:0]        range_mm;
        logic               hit;
    } world_point_t;

    world_point_t point_fifo[$];

    longint roll, pitch, yaw;
    longint sensor_pos[3];
    longint far_mm;
    longint rot[9];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> 15;
    endfunction

    task automatic cordic_sincos(input longint ang, output longint s, output longint c);
        longint z, x, y, t;
        bit     flip;
        z = ang * 131072;
        x = GAIN_START;
        y = 0;
        flip = 1'b0;
        // fold into +-pi/2, negate both outputs afterwards
        if (z > HALF_PI_Z) begin
            z -= PI_Z;
            flip = 1'b1;
        end else if (z < -HALF_PI_Z) begin
            z += PI_Z;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_N; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                x = t;
                z -= ARCTAN[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                x = t;
                z += ARCTAN[i];
            end
        end
        c = clip((x + 16384) >>> 15, -32768, 32768);
        s = clip((y + 16384) >>> 15, -32768, 32768);
        if (flip) begin
            c = -c;
            s = -s;
        end
    endtask

    task automatic rebuild_rotation();
        longint s1, c1, s2, c2, s3, c3;
        longint v[9];
        cordic_sincos(yaw, s1, c1);
        cordic_sincos(pitch, s2, c2);
        cordic_sincos(roll, s3, c3);
        v[0] = qmul(c1, c2);
        v[1] = qmul(qmul(c1, s2), s3) - qmul(c3, s1);
        v[2] = qmul(s1, s3) + qmul(qmul(c1, s2), c3);
        v[3] = qmul(c2, s1);
        v[4] = qmul(c1, c3) + qmul(qmul(s1, s2), s3);
        v[5] = qmul(qmul(c3, s1), s2) - qmul(c1, s3);
        v[6] = -s2;
        v[7] = qmul(c2, s3);
        v[8] = qmul(c2, c3);
        for (int i = 0; i < 9; i++)
            rot[i] = clip(v[i], -65536, 65535);
    endtask

    function automatic world_point_t project_ray(input logic [71:0] req);
        world_point_t wp;
        longint dir[3];
        longint code, prod, lim, rng, acc, p[3];
        dir[0] = longint'($signed(req[15:0]));
        dir[1] = longint'($signed(req[31:16]));
        dir[2] = longint'($signed(req[47:32]));
        code = longint'(req[71:48]);
        prod = code * far_mm;
        lim = (far_mm * 10 - 1) * 16777216;
        wp = '{default: '0};
        if (prod * 10 < lim) begin
            rng = prod >>> 24;
            for (int r = 0; r < 3; r++) begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc += rot[r*3+j] * dir[j];
                p[r] = clip(sensor_pos[r] + ((rng * acc) >>> 30), PT_MIN, PT_MAX);
            end
            wp.px = p[0][24:0];
            wp.py = p[1][24:0];
            wp.pz = p[2][24:0];
            wp.range_mm = rng[15:0];
            wp.hit = 1'b1;
        end
        return wp;
    endfunction

    always @(posedge aclk) begin
        world_point_t want;
        logic signed [24:0] got_x, got_y, got_z;
        logic [15:0] got_r;
        if (!aresetn) begin
            roll = 0;
            pitch = 0;
            yaw = 0;
            sensor_pos[0] = 0;
            sensor_pos[1] = 2000;
            sensor_pos[2] = 0;
            far_mm = 30000;
            for (int i = 0; i < 9; i++)
                rot[i] = (i % 4 == 0) ? 32768 : 0;
            point_fifo.delete();
            errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_ROLL:  begin roll  = longint'($signed(pwdata[15:0])); rebuild_rotation(); end
                    REG_PITCH: begin pitch = longint'($signed(pwdata[15:0])); rebuild_rotation(); end
                    REG_YAW:   begin yaw   = longint'($signed(pwdata[15:0])); rebuild_rotation(); end
                    REG_SX:    sensor_pos[0] = longint'($signed(pwdata[23:0]));
                    REG_SY:    sensor_pos[1] = longint'($signed(pwdata[23:0]));
                    REG_SZ:    sensor_pos[2] = longint'($signed(pwdata[23:0]));
                    REG_FAR:   far_mm = longint'(pwdata[15:0]);
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                point_fifo.push_back(project_ray(s_tdata));
            if (m_tvalid && m_tready) begin
                got_x = m_tdata[24:0];
                got_y = m_tdata[49:25];
                got_z = m_tdata[74:50];
                got_r = m_tdata[90:75];
                if (point_fifo.size() == 0) begin
                    $error("result with no request waiting");
                    errors <= errors + 1;
                end else begin
                    want = point_fifo.pop_front();
                    if (got_x !== want.px || got_y !== want.py || got_z !== want.pz ||
                        got_r !== want.range_mm || m_tuser[0] !== want.hit ||
                        m_tdata[95:91] !== 5'd0) begin
                        if (got_x !== want.px)
                            $error("point_x expected %0d got %0d", want.px, got_x);
                        if (got_y !== want.py)
                            $error("point_y expected %0d got %0d", want.py, got_y);
                        if (got_z !== want.pz)
                            $error("point_z expected %0d got %0d", want.pz, got_z);
                        if (got_r !== want.range_mm)
                            $error("range_mm expected %0d got %0d", want.range_mm, got_r);
                        if (m_tuser[0] !== want.hit)
                            $error("hit expected %0d got %0d", want.hit, m_tuser[0]);
                        if (m_tdata[95:91] !== 5'd0)
                            $error("pad expected 0 got %0h", m_tdata[95:91]);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending <= point_fifo.size();
    end

endmodule

[sim/tb_top.sv]
// Top-level testbench: stimulus, register phases and verdict for depth_ray_to_world_point.
module tb_top;
    import drtwp_pkg::*;

    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PER_PHASE   = 150;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [0:0]  m_tuser;

    int errors;
    int pending;
    int cycles = 0;
    int rays_sent = 0;
    int ready_hold = 0;
    int burst_left = 0;
    longint far_now = 30000;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    depth_ray_to_world_point DUT (.*);

    depth_point_checker checker_i (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result-side backpressure: runs of ready, short stalls, rare long stalls
    always @(posedge aclk) begin
        int r;
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                m_tready <= 1'b1;
                ready_hold <= $urandom_range(0, 30);
            end else if (r < 92) begin
                m_tready <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_tready <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_setup(input int rl, input int pt, input int yw,
                              input int sx, input int sy, input int sz, input int fp);
        // the last request was already taken; stop offering it
        s_tvalid <= 1'b0;
        drain();
        reg_write(REG_ROLL, rl);
        reg_write(REG_PITCH, pt);
        reg_write(REG_YAW, yw);
        reg_write(REG_SX, sx);
        reg_write(REG_SY, sy);
        reg_write(REG_SZ, sz);
        reg_write(REG_FAR, fp);
        reg_write(REG_NONE, $urandom);
        far_now = longint'(fp[15:0]);
    endtask

    task automatic send_ray(input logic [15:0] dx, input logic [15:0] dy,
                            input logic [15:0] dz, input logic [23:0] code);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {code, dz, dy, dx};
        do @(posedge aclk); while (!s_tready);
        rays_sent++;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 99);
            if (gap < 60) gap = 0;
            else if (gap < 92) gap = $urandom_range(1, 3);
            else if (gap < 97) gap = $urandom_range(10, 40);
            else begin
                gap = 0;
                burst_left = $urandom_range(20, 60);
            end
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // first code that fails the far plane margin
    function automatic longint margin_code();
        longint lim, cb;
        if (far_now == 0)
            return 0;
        lim = (far_now * 10 - 1) * 16777216;
        cb = (lim + far_now * 10 - 1) / (far_now * 10);
        return (cb > 16777216) ? 16777216 : cb;
    endfunction

    function automatic logic [23:0] pick_code();
        longint cb;
        int r;
        cb = margin_code();
        r = $urandom_range(0, 99);
        if (r < 35) return 24'($urandom);
        if (r < 70) return (cb > 0) ? 24'($urandom_range(0, 32'(cb - 1))) : 24'd0;
        if (r < 80) return 24'((cb > 0 && $urandom_range(0, 1)) ? cb - 1 : cb);
        if (r < 88) return $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
        return 24'($urandom_range(0, 4095));
    endfunction

    function automatic logic [15:0] pick_dir();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'h8000;
        if (r < 16) return 16'h7FFF;
        if (r < 20) return 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic random_rays(input int n);
        for (int i = 0; i < n; i++)
            send_ray(pick_dir(), pick_dir(), pick_dir(), pick_code());
    endtask

    int rnd_far;

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default registers with the reset identity rotation
        send_ray(16'h7FFF, 16'h0000, 16'h0000, 24'd0);
        send_ray(16'h8000, 16'h8000, 16'h8000, 24'hFFFFFF);
        send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h800000);
        send_ray(16'h0000, 16'h7FFF, 16'h0000, 24'(margin_code() - 1));
        send_ray(16'h0000, 16'h0000, 16'h7FFF, 24'(margin_code()));
        send_ray(16'h8000, 16'h7FFF, 16'h0000, 24'hFFF000);
        send_ray(16'h0000, 16'h0000, 16'h0000, 24'h123456);
        send_ray(16'h5A82, 16'hA57E, 16'h0000, 24'h000001);
        random_rays(PER_PHASE - 8);

        // zero angles written: CORDIC identity instead of exact one
        load_setup(0, 0, 0, 0, 0, 0, 65535);
        send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'(margin_code() - 1));
        send_ray(16'h8000, 16'h8000, 16'h8000, 24'(margin_code() - 1));
        send_ray(16'h7FFF, 16'h0000, 16'h8000, 24'(margin_code()));
        random_rays(PER_PHASE - 3);

        // extreme angles and sensor position, smallest far plane
        load_setup(25736, -25736, 25736, 8388607, -8388608, 8388607, 1);
        send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'd0);
        send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'(margin_code() - 1));
        random_rays(PER_PHASE - 2);

        // zero far plane: nothing is a hit
        load_setup(-25736, 25736, -25736, -8388608, 8388607, -8388608, 0);
        send_ray(16'h7FFF, 16'h8000, 16'h7FFF, 24'd0);
        random_rays(PER_PHASE - 1);

        for (int ph = 0; ph < 4; ph++) begin
            rnd_far = (ph == 0) ? 65535 : $urandom_range(1, 65535);
            load_setup($urandom_range(0, 51472) - 25736, $urandom_range(0, 51472) - 25736,
                       $urandom_range(0, 51472) - 25736,
                       $urandom_range(0, 16777215) - 8388608,
                       $urandom_range(0, 16777215) - 8388608,
                       $urandom_range(0, 16777215) - 8388608, rnd_far);
            random_rays(PER_PHASE);
        end

        s_tvalid <= 1'b0;
        drain();
        repeat (20) @(posedge aclk);
        $display("%0d rays over 8 register settings: extreme and random angles,", rays_sent);
        $display("sensor positions, far planes including zero, and the margin edge");
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
